// ===== src/dsws_pkg.sv =====
// ---------------------------------------------------------------------------
// dsws_pkg
// shared types and constants of the dual stream window statistics core
// ---------------------------------------------------------------------------
package dsws_pkg;

    localparam int MAX_WINDOW   = 64;
    localparam int SAMPLE_BITS  = 24;
    localparam int COUNT_BITS   = 7;
    localparam int SUM_BITS     = 31;
    localparam int SQSUM_BITS   = 55;
    localparam int STAT_BITS    = 32;
    localparam int DVD_BITS     = 77;
    localparam int DVS_BITS     = 13;
    localparam int DIV_STEPS    = DVD_BITS;
    localparam int SQRT_STEPS   = 32;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = 2;
    localparam int OUT_BITS     = 240;

    localparam logic [COUNT_BITS-1:0] WINDOW_RESET = 7'd50;
    localparam logic [COUNT_BITS-1:0] WINDOW_CAP   = 7'd64;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    localparam logic REG_WINDOW = 1'b0;

    typedef struct packed {
        logic                   op;
        logic                   sel;
        logic [SAMPLE_BITS-1:0] sample;
    } t_item;

    typedef struct packed {
        logic [COUNT_BITS-1:0]  count;
        logic [SUM_BITS-1:0]    sum;
        logic [SQSUM_BITS-1:0]  sqsum;
        logic [SAMPLE_BITS-1:0] min;
        logic [SAMPLE_BITS-1:0] max;
    } t_snap;

    typedef struct packed {
        logic [STAT_BITS-1:0]   dev;
        logic [STAT_BITS-1:0]   mean;
        logic [SAMPLE_BITS-1:0] max;
        logic [SAMPLE_BITS-1:0] min;
        logic [COUNT_BITS-1:0]  count;
    } t_stats;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIVM,
        ST_DIVV,
        ST_SQRT,
        ST_OUT
    } t_state;

endpackage

// ===== src/dsws_front.sv =====
// ---------------------------------------------------------------------------
// dsws_front
// input request queue between the stream port and the statistics back end
// ---------------------------------------------------------------------------
module dsws_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dsws_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_pop,
    output dsws_pkg::t_item o_item
);

    dsws_pkg::t_item r_mem [dsws_pkg::FIFO_DEPTH];
    logic [dsws_pkg::FIFO_AW-1:0] r_wr;
    logic [dsws_pkg::FIFO_AW-1:0] r_rd;
    logic [dsws_pkg::FIFO_AW:0]   r_cnt;
    logic push;
    logic pop;

    assign o_ready = (r_cnt != dsws_pkg::FIFO_AW'(0) + (dsws_pkg::FIFO_AW+1)'(dsws_pkg::FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== src/dsws_accum.sv =====
// ---------------------------------------------------------------------------
// dsws_accum
// per-stream count, sum, sum of squares, min and max; hands a snapshot to
// the report unit and clears on a report request
// ---------------------------------------------------------------------------
module dsws_accum (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  dsws_pkg::t_item                     i_item,
    output logic                                o_pop,
    input  logic [dsws_pkg::COUNT_BITS-1:0]     i_window,
    input  logic                                i_rep_idle,
    output logic                                o_go,
    output dsws_pkg::t_snap [1:0]               o_snap
);

    dsws_pkg::t_snap [1:0] r_st;
    logic [dsws_pkg::COUNT_BITS-1:0] limit;
    dsws_pkg::t_snap cur;
    logic [2*dsws_pkg::SAMPLE_BITS-1:0] sq;
    logic is_add;
    logic take;

    assign limit  = (i_window > dsws_pkg::WINDOW_CAP) ? dsws_pkg::WINDOW_CAP : i_window;
    assign is_add = (i_item.op == dsws_pkg::OP_ADD);
    assign o_go   = i_valid && !is_add && i_rep_idle;
    assign o_pop  = i_valid && (is_add || i_rep_idle);
    assign o_snap = r_st;
    assign cur    = r_st[i_item.sel];
    assign sq     = i_item.sample * i_item.sample;
    assign take   = i_valid && is_add && (cur.count < limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_go) begin
            r_st <= '0;
        end else if (take) begin
            if (cur.count == '0) begin
                r_st[i_item.sel].min <= i_item.sample;
                r_st[i_item.sel].max <= i_item.sample;
            end else begin
                if (i_item.sample < cur.min) begin
                    r_st[i_item.sel].min <= i_item.sample;
                end
                if (i_item.sample > cur.max) begin
                    r_st[i_item.sel].max <= i_item.sample;
                end
            end
            r_st[i_item.sel].sum   <= cur.sum + dsws_pkg::SUM_BITS'(i_item.sample);
            r_st[i_item.sel].sqsum <= cur.sqsum + dsws_pkg::SQSUM_BITS'(sq);
            r_st[i_item.sel].count <= cur.count + 1'b1;
        end
    end

endmodule

// ===== src/dsws_report.sv =====
// ---------------------------------------------------------------------------
// dsws_report
// report unit: per stream a mean divide, a variance divide and an integer
// square root, one bit or one root digit per cycle, then an output register
// ---------------------------------------------------------------------------
module dsws_report (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  dsws_pkg::t_snap [1:0] i_snap,
    output logic                  o_idle,
    output logic                  o_valid,
    input  logic                  i_ready,
    output dsws_pkg::t_stats [1:0] o_stats
);

    dsws_pkg::t_state r_state;
    dsws_pkg::t_state n_state;
    dsws_pkg::t_snap [1:0] r_snap;
    dsws_pkg::t_stats [1:0] r_res;
    logic                               r_s;
    logic [61:0]                        r_pa;
    logic [61:0]                        r_pb;
    logic [dsws_pkg::DVD_BITS-1:0]      r_dvd;
    logic [dsws_pkg::DVS_BITS-1:0]      r_dvs;
    logic [dsws_pkg::DVS_BITS-1:0]      r_rem;
    logic [6:0]                         r_cnt;
    logic [63:0]                        r_rq;
    logic [32:0]                        r_srem;
    logic [31:0]                        r_root;

    dsws_pkg::t_snap                    cur;
    logic [dsws_pkg::DVS_BITS:0]        div_sh;
    logic                               div_ge;
    logic [dsws_pkg::DVS_BITS-1:0]      div_rem_n;
    logic [dsws_pkg::DVD_BITS-1:0]      div_q_n;
    logic [34:0]                        sq_sh;
    logic [34:0]                        sq_trial;
    logic                               sq_ge;
    logic [31:0]                        root_n;
    logic [61:0]                        num;
    logic                               div_last;
    logic                               sqrt_last;
    logic                               empty;

    assign cur       = r_snap[r_s];
    assign empty     = (cur.count == '0);
    assign div_sh    = {r_rem, r_dvd[dsws_pkg::DVD_BITS-1]};
    assign div_ge    = (div_sh >= {1'b0, r_dvs});
    assign div_rem_n = div_ge ? dsws_pkg::DVS_BITS'(div_sh - {1'b0, r_dvs})
                              : dsws_pkg::DVS_BITS'(div_sh);
    assign div_q_n   = {r_dvd[dsws_pkg::DVD_BITS-2:0], div_ge};
    assign sq_sh     = {r_srem, r_rq[63:62]};
    assign sq_trial  = {1'b0, r_root, 2'b01};
    assign sq_ge     = (sq_sh >= sq_trial);
    assign root_n    = {r_root[30:0], sq_ge};
    assign num       = r_pa - r_pb;
    assign div_last  = (r_cnt == 7'(dsws_pkg::DIV_STEPS - 1));
    assign sqrt_last = (r_cnt == 7'(dsws_pkg::SQRT_STEPS - 1));
    assign o_stats   = r_res;

    always_comb begin
        n_state = r_state;
        case (r_state)
            dsws_pkg::ST_IDLE: begin
                if (i_go) begin
                    n_state = dsws_pkg::ST_MUL;
                end
            end
            dsws_pkg::ST_MUL:  n_state = dsws_pkg::ST_DIVM;
            dsws_pkg::ST_DIVM: begin
                if (div_last) begin
                    n_state = dsws_pkg::ST_DIVV;
                end
            end
            dsws_pkg::ST_DIVV: begin
                if (div_last) begin
                    n_state = dsws_pkg::ST_SQRT;
                end
            end
            dsws_pkg::ST_SQRT: begin
                if (sqrt_last) begin
                    n_state = r_s ? dsws_pkg::ST_OUT : dsws_pkg::ST_MUL;
                end
            end
            dsws_pkg::ST_OUT: begin
                if (i_ready) begin
                    n_state = dsws_pkg::ST_IDLE;
                end
            end
            default: n_state = dsws_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_idle  = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            dsws_pkg::ST_IDLE: o_idle  = 1'b1;
            dsws_pkg::ST_OUT:  o_valid = 1'b1;
            default: begin
                o_idle  = 1'b0;
                o_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsws_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            dsws_pkg::ST_IDLE: begin
                r_snap <= i_snap;
                r_s    <= 1'b0;
            end
            dsws_pkg::ST_MUL: begin
                r_pa  <= 62'(cur.count * cur.sqsum);
                r_pb  <= 62'(cur.sum * cur.sum);
                r_dvd <= dsws_pkg::DVD_BITS'({cur.sum, 8'd0});
                r_dvs <= dsws_pkg::DVS_BITS'(cur.count);
                r_rem <= '0;
                r_cnt <= '0;
            end
            dsws_pkg::ST_DIVM: begin
                if (div_last) begin
                    r_res[r_s].mean <= div_q_n[31:0];
                    // variance numerator scaled by 2^16 over n squared
                    r_dvd <= dsws_pkg::DVD_BITS'({num, 16'd0});
                    r_dvs <= dsws_pkg::DVS_BITS'(cur.count * cur.count);
                    r_rem <= '0;
                    r_cnt <= '0;
                end else begin
                    r_dvd <= div_q_n;
                    r_rem <= div_rem_n;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            dsws_pkg::ST_DIVV: begin
                if (div_last) begin
                    r_rq   <= div_q_n[63:0];
                    r_srem <= '0;
                    r_root <= '0;
                    r_cnt  <= '0;
                end else begin
                    r_dvd <= div_q_n;
                    r_rem <= div_rem_n;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            dsws_pkg::ST_SQRT: begin
                r_rq   <= {r_rq[61:0], 2'b00};
                r_srem <= sq_ge ? 33'(sq_sh - sq_trial) : 33'(sq_sh);
                r_root <= root_n;
                r_cnt  <= r_cnt + 1'b1;
                if (sqrt_last) begin
                    r_res[r_s].count <= cur.count;
                    r_res[r_s].dev   <= empty ? '0 : root_n;
                    r_res[r_s].min   <= empty ? '0 : cur.min;
                    r_res[r_s].max   <= empty ? '0 : cur.max;
                    if (empty) begin
                        r_res[r_s].mean <= '0;
                    end
                    r_s <= 1'b1;
                end
            end
            default: begin
                r_s <= r_s;
            end
        endcase
    end

endmodule

// ===== src/dual_stream_window_statistics_core.sv =====
// ---------------------------------------------------------------------------
// dual_stream_window_statistics_core
// windowed min, max, mean and deviation for two sample streams
// ---------------------------------------------------------------------------
// add requests: one per cycle via a four-entry queue when not held, no result
// report request: result from the bit-serial divider and the root-digit sqrt,
//   shared by both streams and run for one stream after the other
// adds flow during a report; a second report waits, holding adds behind it
// reset (synchronous, active low) clears the accumulators, window_size = 50
// ---------------------------------------------------------------------------
module dual_stream_window_statistics_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,   // sample
    input  logic [1:0]   s_axis_tuser,   // operation, stream_select
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // time_count, time_min, time_max, time_mean, time_deviation, size_count,
    // size_min, size_max, size_mean, size_deviation, zero pad
    output logic [239:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [dsws_pkg::COUNT_BITS-1:0] r_window;
    dsws_pkg::t_item in_item;
    dsws_pkg::t_item q_item;
    dsws_pkg::t_snap [1:0] snap;
    dsws_pkg::t_stats [1:0] stats;
    logic q_valid;
    logic q_pop;
    logic go;
    logic rep_idle;
    logic reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == dsws_pkg::REG_WINDOW);
    assign prdata  = reg_hit ? {25'd0, r_window} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= dsws_pkg::WINDOW_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_window <= pwdata[dsws_pkg::COUNT_BITS-1:0];
        end
    end

    assign in_item.op     = s_axis_tuser[0];
    assign in_item.sel    = s_axis_tuser[1];
    assign in_item.sample = s_axis_tdata;

    dsws_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_item)
    );

    dsws_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_item     (q_item),
        .o_pop      (q_pop),
        .i_window   (r_window),
        .i_rep_idle (rep_idle),
        .o_go       (go),
        .o_snap     (snap)
    );

    dsws_report u_report (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_snap  (snap),
        .o_idle  (rep_idle),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_stats (stats)
    );

    assign m_axis_tdata = {2'b00, stats[1].dev, stats[1].mean, stats[1].max, stats[1].min,
                           stats[1].count, stats[0].dev, stats[0].mean, stats[0].max,
                           stats[0].min, stats[0].count};

endmodule

// ===== src/dsws_checker.sv =====
// ---------------------------------------------------------------------------
// dsws_checker
// port-level checks of the statistics core
// ---------------------------------------------------------------------------
module dsws_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [239:0] m_axis_tdata,
    input logic         psel,
    input logic         penable,
    input logic         pwrite,
    input logic [2:0]   paddr,
    input logic [31:0]  pwdata,
    input logic [31:0]  prdata
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && paddr[2] == dsws_pkg::REG_WINDOW
        ##1 paddr[2] == dsws_pkg::REG_WINDOW
        |-> prdata[6:0] == $past(pwdata[6:0]))
        else $error("window register readback mismatch");

    a_empty_t: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[6:0] == 7'd0 |-> m_axis_tdata[118:7] == '0)
        else $error("empty time stream reports nonzero fields");

    a_empty_s: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[125:119] == 7'd0 |-> m_axis_tdata[237:126] == '0)
        else $error("empty size stream reports nonzero fields");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[6:0] <= 7'd64 && m_axis_tdata[125:119] <= 7'd64)
        else $error("count beyond window cap");

endmodule

bind dual_stream_window_statistics_core dsws_checker u_dsws_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);
